/* rtl/spfa_pkg.sv */
// Shared package for the SPFA shortest-path block: field widths, codes, FSM states
// and the saturating distance add. No dependencies.
`timescale 1ns / 1ps
package spfa_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF    = 512;
	localparam int RESULT_LIMIT     = 64;

	localparam int VID_W  = 6;
	localparam int WT_W   = 16;
	localparam int DIST_W = 24;
	localparam int VC_W   = 7;
	localparam int MODE_W = 2;
	localparam int STAT_W = 2;

	localparam logic [VC_W-1:0] VC_RESET = 7'd64;

	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

	localparam logic [STAT_W-1:0] ST_PATH   = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STAT_W-1:0] ST_NEGCYC = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

	localparam logic signed [DIST_W-1:0] DIST_MAX = 24'sh7FFFFF;
	localparam logic signed [DIST_W-1:0] DIST_MIN = 24'sh800000;

	typedef struct packed {
		logic [VID_W-1:0]       tail;
		logic [VID_W-1:0]       head;
		logic signed [WT_W-1:0] weight;
	} edge_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_INIT,
		S_POP,
		S_U1,
		S_U2,
		S_E0,
		S_E1,
		S_E2,
		S_T1,
		S_W,
		S_RD,
		S_EMIT
	} state_t;

	function automatic logic signed [DIST_W-1:0] sat_add(
		input logic signed [DIST_W-1:0] a,
		input logic signed [WT_W-1:0]   b
	);
		logic signed [DIST_W:0] s;
		s = {a[DIST_W-1], a} + {{(DIST_W+1-WT_W){b[WT_W-1]}}, b};
		if (s[DIST_W] != s[DIST_W-1])
			return s[DIST_W] ? DIST_MIN : DIST_MAX;
		return s[DIST_W-1:0];
	endfunction

endpackage

/* rtl/spfa_cmd_if.sv */
// Input channel of the SPFA block: valid/ready plus one command item.
// Depends on spfa_pkg.
`timescale 1ns / 1ps
interface spfa_cmd_if import spfa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [MODE_W-1:0]      mode;
	logic [VID_W-1:0]       edge_from;
	logic [VID_W-1:0]       edge_to;
	logic signed [WT_W-1:0] edge_weight;
	logic [VID_W-1:0]       source_vertex;
	logic [VID_W-1:0]       target_vertex;

	modport source (output valid, mode, edge_from, edge_to, edge_weight,
		source_vertex, target_vertex, input ready);
	modport sink (input valid, mode, edge_from, edge_to, edge_weight,
		source_vertex, target_vertex, output ready);
endinterface

/* rtl/spfa_res_if.sv */
// Output channel of the SPFA block: valid/ready plus one result item.
// Depends on spfa_pkg.
`timescale 1ns / 1ps
interface spfa_res_if import spfa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [VID_W-1:0]  path_vertex;
	logic              last;

	modport source (output valid, status, path_vertex, last, input ready);
	modport sink (input valid, status, path_vertex, last, output ready);
endinterface

/* rtl/spfa_edge_store.sv */
// Edge table: append-only memory with fill count, one registered read port.
// Depends on spfa_pkg.
`timescale 1ns / 1ps
module spfa_edge_store import spfa_pkg::*; #(
	parameter int MAX_EDGES = MAX_EDGES_DEF,
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
	localparam int ECW = $clog2(MAX_EDGES + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clear,
	input  logic           append,
	input  edge_t          wr_edge,
	input  logic           rd_en,
	input  logic [EAW-1:0] rd_addr,
	output edge_t          rd_edge,
	output logic [ECW-1:0] count,
	output logic           full
);

	edge_t          mem [MAX_EDGES];
	logic [ECW-1:0] count_q;

	assign count = count_q;
	assign full  = (32'(count_q) >= MAX_EDGES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (clear)
			count_q <= '0;
		else if (append && !full)
			count_q <= count_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (append && !full)
			mem[count_q[EAW-1:0]] <= wr_edge;
		if (rd_en)
			rd_edge <= mem[rd_addr];
	end

endmodule

/* rtl/spfa_work_fifo.sv */
// Circular work queue of vertex ids held in a memory; registered pop data.
// Depends on spfa_pkg.
`timescale 1ns / 1ps
module spfa_work_fifo import spfa_pkg::*; #(
	parameter int DEPTH = MAX_VERTICES_DEF,
	parameter int W = 6,
	localparam int AW = $clog2(DEPTH),
	localparam int FW = $clog2(DEPTH + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         clear,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty,
	output logic         full
);

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic [FW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign empty   = (fill_q == '0);
	assign full    = (32'(fill_q) >= DEPTH);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (32'(p) == DEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else if (clear) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (do_push && !do_pop)
				fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= push_data;
		if (do_pop)
			pop_data <= mem[rd_ptr_q];
	end

endmodule

/* rtl/spfa_vtx_state.sv */
// Per-vertex state memory (distance, valid, predecessor, queued mark, enqueue
// count) with registered read, plus the relax compare on the read entry. Uses spfa_pkg.
`timescale 1ns / 1ps
module spfa_vtx_state import spfa_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	localparam int VW = $clog2(MAX_VERTICES),
	localparam int PW = $clog2(MAX_VERTICES + 1),
	localparam int CW = $clog2(MAX_VERTICES + 2)
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [VW-1:0]            raddr,
	input  logic                     we,
	input  logic [VW-1:0]            waddr,
	input  logic signed [DIST_W-1:0] w_dist,
	input  logic                     w_valid,
	input  logic [PW-1:0]            w_pred,
	input  logic                     w_queued,
	input  logic [CW-1:0]            w_cnt,
	output logic signed [DIST_W-1:0] r_dist,
	output logic                     r_valid,
	output logic [PW-1:0]            r_pred,
	output logic                     r_queued,
	output logic [CW-1:0]            r_cnt,
	input  logic signed [DIST_W-1:0] base_dist,
	input  logic signed [WT_W-1:0]   weight,
	output logic signed [DIST_W-1:0] cand,
	output logic                     improve
);

	localparam int EW = DIST_W + 1 + PW + 1 + CW;

	logic [EW-1:0] mem [MAX_VERTICES];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= {w_dist, w_valid, w_pred, w_queued, w_cnt};
		if (re)
			rd_q <= mem[raddr];
	end

	assign {r_dist, r_valid, r_pred, r_queued, r_cnt} = rd_q;

	// infinite head always improves; otherwise strictly smaller wins
	assign cand    = sat_add(base_dist, weight);
	assign improve = !r_valid || (cand < r_dist);

endmodule

/* rtl/spfa_shortest_path.sv */
// SPFA shortest-path block: top level with control FSM and path stack.
// Depends on spfa_pkg, spfa_cmd_if, spfa_res_if, spfa_edge_store,
// spfa_work_fifo and spfa_vtx_state.
// Clear and add items are taken in the idle state. A query first inits each
// vertex, then for each dequeued vertex reads its state and scans all stored
// edges, relaxing those leaving it; then it walks the path and emits its vertices.
// The edge memory read port sets the scan rate; one item is worked at a time.
// Reset empties the edge table and sets vertex_count to 64.
`timescale 1ns / 1ps
module spfa_shortest_path import spfa_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_EDGES = MAX_EDGES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [VC_W-1:0] cfg_data,
	spfa_cmd_if.sink        cmd,
	spfa_res_if.source      res
);

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int PW  = $clog2(MAX_VERTICES + 1);
	localparam int CW  = $clog2(MAX_VERTICES + 2);
	localparam int NW  = $clog2(MAX_VERTICES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int PSD = (MAX_VERTICES < RESULT_LIMIT) ? MAX_VERTICES : RESULT_LIMIT;
	localparam int PAW = $clog2(PSD);
	localparam int PLW = $clog2(PSD + 1);

	state_t state_q, state_d;

	logic [VC_W-1:0]          vc_q;
	logic [NW-1:0]            nv_c, nv_q;
	logic [VW-1:0]            src_q, tgt_q, idx_q, u_q, v_q, cur_q;
	logic [STAT_W-1:0]        err_q;
	logic signed [DIST_W-1:0] du_q;
	logic signed [WT_W-1:0]   w_q;
	logic [ECW-1:0]           e_q, e_next;
	logic [PLW-1:0]           len_q;
	logic [PAW-1:0]           p_q;

	logic              res_valid_q;
	logic [STAT_W-1:0] res_status_q;
	logic [VID_W-1:0]  res_vertex_q;
	logic              res_last_q;
	logic              out_free;
	logic              res_load;
	logic [STAT_W-1:0] ld_status;
	logic [VID_W-1:0]  ld_vertex;
	logic              ld_last;

	logic           cmd_acc, q_bad;
	logic           edge_clear, edge_append, edge_re, edge_full;
	logic [EAW-1:0] edge_raddr;
	edge_t          edge_wr, er;
	logic [ECW-1:0] edge_cnt;

	logic          fifo_clear, fifo_push, fifo_pop, fifo_empty, fifo_full;
	logic [VW-1:0] fifo_pdata, fifo_rdata;

	logic                     vtx_re, vtx_we;
	logic [VW-1:0]            vtx_raddr, vtx_waddr;
	logic signed [DIST_W-1:0] w_dist, vr_dist, cand;
	logic                     w_valid, vr_valid, w_queued, vr_queued, improve;
	logic [PW-1:0]            w_pred, vr_pred;
	logic [CW-1:0]            w_cnt, vr_cnt, cnt_new;

	logic [VW-1:0] stack [PSD];
	logic [VW-1:0] stack_rd;
	logic          stack_we, stack_re;

	logic match, last_edge, enq, neg, len_full, pred_none;

	// effective vertex count: zero used as one, clamped to capacity
	always_comb begin
		if (vc_q == '0)
			nv_c = NW'(1);
		else if (32'(vc_q) > MAX_VERTICES)
			nv_c = NW'(MAX_VERTICES);
		else
			nv_c = NW'(vc_q);
	end

	assign cmd_acc   = cmd.valid && cmd.ready;
	assign q_bad     = (32'(cmd.source_vertex) >= 32'(nv_c)) ||
		(32'(cmd.target_vertex) >= 32'(nv_c));
	assign out_free  = !res_valid_q || res.ready;
	assign e_next    = e_q + 1'b1;
	assign last_edge = (e_next == edge_cnt);
	assign match     = (32'(er.tail) == 32'(u_q)) && (32'(er.head) < 32'(nv_q));
	assign enq       = !vr_queued && !fifo_full;
	assign cnt_new   = vr_cnt + CW'(enq);
	assign neg       = improve && enq && (32'(cnt_new) > 32'(nv_q));
	assign len_full  = (32'(len_q) >= 32'(nv_q)) || (32'(len_q) >= RESULT_LIMIT);
	assign pred_none = (32'(vr_pred) >= MAX_VERTICES);

	assign edge_wr = '{tail: cmd.edge_from, head: cmd.edge_to, weight: cmd.edge_weight};

	spfa_edge_store #(.MAX_EDGES(MAX_EDGES)) u_edges (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (edge_clear),
		.append  (edge_append),
		.wr_edge (edge_wr),
		.rd_en   (edge_re),
		.rd_addr (edge_raddr),
		.rd_edge (er),
		.count   (edge_cnt),
		.full    (edge_full)
	);

	spfa_work_fifo #(.DEPTH(MAX_VERTICES), .W(VW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (fifo_clear),
		.push      (fifo_push),
		.push_data (fifo_pdata),
		.pop       (fifo_pop),
		.pop_data  (fifo_rdata),
		.empty     (fifo_empty),
		.full      (fifo_full)
	);

	spfa_vtx_state #(.MAX_VERTICES(MAX_VERTICES)) u_vtx (
		.clk       (clk),
		.re        (vtx_re),
		.raddr     (vtx_raddr),
		.we        (vtx_we),
		.waddr     (vtx_waddr),
		.w_dist    (w_dist),
		.w_valid   (w_valid),
		.w_pred    (w_pred),
		.w_queued  (w_queued),
		.w_cnt     (w_cnt),
		.r_dist    (vr_dist),
		.r_valid   (vr_valid),
		.r_pred    (vr_pred),
		.r_queued  (vr_queued),
		.r_cnt     (vr_cnt),
		.base_dist (du_q),
		.weight    (w_q),
		.cand      (cand),
		.improve   (improve)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					if (cmd.mode == MODE_ADD && edge_full)
						state_d = S_ERR;
					else if (cmd.mode == MODE_QUERY)
						state_d = q_bad ? S_ERR : S_INIT;
				end
			end
			S_ERR:
				if (out_free)
					state_d = S_IDLE;
			S_INIT:
				if (32'(idx_q) + 1 == 32'(nv_q))
					state_d = S_POP;
			S_POP:
				state_d = fifo_empty ? S_T1 : S_U1;
			S_U1:
				state_d = S_U2;
			S_U2: begin
				if (!vr_valid || edge_cnt == '0)
					state_d = S_POP;
				else
					state_d = S_E0;
			end
			S_E0:
				state_d = S_E1;
			S_E1: begin
				if (match)
					state_d = S_E2;
				else if (last_edge)
					state_d = S_POP;
			end
			S_E2: begin
				if (neg)
					state_d = S_ERR;
				else if (last_edge)
					state_d = S_POP;
				else
					state_d = S_E0;
			end
			S_T1:
				state_d = vr_valid ? S_W : S_ERR;
			S_W: begin
				if (len_full)
					state_d = S_ERR;
				else if (pred_none)
					state_d = S_RD;
			end
			S_RD:
				state_d = S_EMIT;
			S_EMIT:
				if (out_free && p_q == '0)
					state_d = S_IDLE;
			default:
				state_d = S_IDLE;
		endcase
	end

	// datapath and memory controls
	always_comb begin
		cmd.ready   = 1'b0;
		edge_clear  = 1'b0;
		edge_append = 1'b0;
		edge_re     = 1'b0;
		edge_raddr  = e_q[EAW-1:0];
		fifo_clear  = 1'b0;
		fifo_push   = 1'b0;
		fifo_pdata  = v_q;
		fifo_pop    = 1'b0;
		vtx_re      = 1'b0;
		vtx_raddr   = u_q;
		vtx_we      = 1'b0;
		vtx_waddr   = u_q;
		w_dist      = vr_dist;
		w_valid     = vr_valid;
		w_pred      = vr_pred;
		w_queued    = vr_queued;
		w_cnt       = vr_cnt;
		stack_we    = 1'b0;
		stack_re    = 1'b0;
		res_load    = 1'b0;
		ld_status   = err_q;
		ld_vertex   = '0;
		ld_last     = 1'b1;
		case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd_acc) begin
					edge_clear  = (cmd.mode == MODE_CLEAR);
					edge_append = (cmd.mode == MODE_ADD);
					fifo_clear  = (cmd.mode == MODE_QUERY);
				end
			end
			S_ERR:
				res_load = out_free;
			S_INIT: begin
				vtx_we     = 1'b1;
				vtx_waddr  = idx_q;
				w_dist     = '0;
				w_valid    = (idx_q == src_q);
				w_pred     = PW'(MAX_VERTICES);
				w_queued   = (idx_q == src_q);
				w_cnt      = CW'(idx_q == src_q);
				fifo_push  = (idx_q == src_q);
				fifo_pdata = src_q;
			end
			S_POP: begin
				if (fifo_empty) begin
					vtx_re    = 1'b1;
					vtx_raddr = tgt_q;
				end else begin
					fifo_pop = 1'b1;
				end
			end
			S_U1: begin
				vtx_re    = 1'b1;
				vtx_raddr = fifo_rdata;
			end
			S_U2: begin
				vtx_we   = 1'b1;
				w_queued = 1'b0;
			end
			S_E0:
				edge_re = 1'b1;
			S_E1: begin
				if (match) begin
					vtx_re    = 1'b1;
					vtx_raddr = VW'(er.head);
				end else if (!last_edge) begin
					edge_re    = 1'b1;
					edge_raddr = e_next[EAW-1:0];
				end
			end
			S_E2: begin
				if (improve) begin
					vtx_we    = 1'b1;
					vtx_waddr = v_q;
					w_dist    = cand;
					w_valid   = 1'b1;
					w_pred    = PW'(u_q);
					w_queued  = vr_queued || enq;
					w_cnt     = cnt_new;
					fifo_push = enq;
				end
			end
			S_W: begin
				if (!len_full) begin
					stack_we = 1'b1;
					if (!pred_none) begin
						vtx_re    = 1'b1;
						vtx_raddr = VW'(vr_pred);
					end
				end
			end
			S_RD:
				stack_re = 1'b1;
			S_EMIT: begin
				ld_status = ST_PATH;
				ld_vertex = VID_W'(stack_rd);
				ld_last   = (p_q == '0);
				if (out_free) begin
					res_load = 1'b1;
					stack_re = (p_q != '0);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vc_q        <= VC_RESET;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				vc_q <= cfg_data;
			if (res_load)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q <= ld_status;
			res_vertex_q <= ld_vertex;
			res_last_q   <= ld_last;
		end
		case (state_q)
			S_IDLE: begin
				src_q <= VW'(cmd.source_vertex);
				tgt_q <= VW'(cmd.target_vertex);
				nv_q  <= nv_c;
				idx_q <= '0;
				err_q <= (cmd.mode == MODE_ADD) ? ST_FULL : ST_EMPTY;
			end
			S_INIT:
				idx_q <= idx_q + 1'b1;
			S_U1:
				u_q <= fifo_rdata;
			S_U2: begin
				du_q <= vr_dist;
				e_q  <= '0;
			end
			S_E1: begin
				v_q <= VW'(er.head);
				w_q <= er.weight;
				if (!match)
					e_q <= e_next;
			end
			S_E2: begin
				e_q   <= e_next;
				err_q <= ST_NEGCYC;
				if (improve && v_q == u_q)
					du_q <= cand;
			end
			S_T1: begin
				cur_q <= tgt_q;
				len_q <= '0;
				err_q <= ST_EMPTY;
			end
			S_W: begin
				err_q <= ST_NEGCYC;
				if (!len_full) begin
					len_q <= len_q + 1'b1;
					p_q   <= PAW'(len_q);
					cur_q <= VW'(vr_pred);
				end
			end
			S_EMIT:
				if (out_free && p_q != '0)
					p_q <= p_q - 1'b1;
			default: ;
		endcase
	end

	// path stack memory; read address p_q (p_q - 1 in S_EMIT), written at len_q
	always_ff @(posedge clk) begin
		if (stack_we)
			stack[len_q[PAW-1:0]] <= cur_q;
		if (stack_re)
			stack_rd <= stack[(state_q == S_EMIT) ? p_q - 1'b1 : p_q];
	end

	assign res.valid       = res_valid_q;
	assign res.status      = res_status_q;
	assign res.path_vertex = res_vertex_q;
	assign res.last        = res_last_q;

	a_fifo_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> !fifo_full)
		else $error("work queue pushed while full");

	a_fifo_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_pop |-> !fifo_empty)
		else $error("work queue popped while empty");

	a_vtx_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(vtx_we && vtx_re && vtx_waddr == vtx_raddr))
		else $error("vertex state read and written at one entry");

	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(edge_cnt) <= MAX_EDGES)
		else $error("edge count beyond capacity");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.ready) |=> !$past(res_load))
		else $error("result overwritten before it was taken");

endmodule
